FILE: design/rwl_pkg.sv
// Shared types and codes of the readers-writer lock controller.
`default_nettype none

package rwl_pkg;

  localparam int TID_W = 4;
  localparam int CMD_W = 3;
  localparam int ST_W  = 3;

  localparam logic KIND_RESP = 1'b0;
  localparam logic KIND_WAKE = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_RD_LOCK   = 3'd0,
    CMD_RD_TRY    = 3'd1,
    CMD_RD_UNLOCK = 3'd2,
    CMD_WR_LOCK   = 3'd3,
    CMD_WR_TRY    = 3'd4,
    CMD_WR_UNLOCK = 3'd5
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_GRANTED  = 3'd0,
    ST_BLOCKED  = 3'd1,
    ST_REFUSED  = 3'd2,
    ST_RELEASED = 3'd3,
    ST_IGNORED  = 3'd4
  } status_e;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [TID_W-1:0] thread_id;
  } req_t;

  typedef struct packed {
    logic             kind;
    logic [ST_W-1:0]  status;
    logic [TID_W-1:0] thread_out;
    logic             last;
  } res_t;

  typedef struct packed {
    logic             push;
    logic             pop;
    logic             clear;
    logic [TID_W-1:0] id;
  } q_ctrl_t;

  typedef struct packed {
    logic member;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

FILE: design/rwl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rwl_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: design/rwl_queue.sv
// Thread wait queue: circular buffer in RAM plus membership bits.
`default_nettype none

module rwl_queue import rwl_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire q_ctrl_t          ctrl_i,
  output q_stat_t               stat_o,
  output logic      [TID_W-1:0] tid_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [PW-1:0]    head_q, head_d;
  logic [CW-1:0]    count_q, count_d;
  logic [DEPTH-1:0] bits_q, bits_d;
  logic [PW:0]      sum;
  logic [PW:0]      tail;
  logic [DEPTH-1:0] sel_push;
  logic [DEPTH-1:0] sel_clr;
  logic             member;
  logic             do_push;

  assign sum      = (PW + 1)'(head_q) + (PW + 1)'(count_q);
  assign tail     = (sum >= (PW + 1)'(DEPTH)) ? sum - (PW + 1)'(DEPTH) : sum;
  assign sel_push = DEPTH'(1) << ctrl_i.id;
  assign sel_clr  = DEPTH'(1) << tid_o;
  assign member   = |(bits_q & sel_push);
  assign do_push  = ctrl_i.push && !member && (count_q < CW'(DEPTH));

  always_comb begin
    bits_d  = bits_q;
    head_d  = head_q;
    count_d = count_q;
    if (ctrl_i.clear) begin
      bits_d = bits_d & ~sel_clr;
    end
    if (do_push) begin
      bits_d  = bits_d | sel_push;
      count_d = count_q + CW'(1);
    end else if (ctrl_i.pop) begin
      count_d = count_q - CW'(1);
      head_d  = (head_q == PW'(DEPTH - 1)) ? '0 : head_q + PW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      bits_q  <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      bits_q  <= bits_d;
    end
  end

  rwl_ram #(
    .WIDTH(TID_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (do_push),
    .waddr_i(tail[PW-1:0]),
    .wdata_i(ctrl_i.id),
    .raddr_i(head_q),
    .rdata_o(tid_o)
  );

  assign stat_o.member = member;
  assign stat_o.empty  = (count_q == '0);

endmodule

`default_nettype wire

FILE: design/readers_writer_lock_controller.sv
// Readers-writer lock controller with writer preference and wake sequencing.
// A request is registered on acceptance and evaluated in the cycle after; its response appears on the
// following cycle. Wakes follow one per cycle, popped through each queue's RAM read port.
// Busy is high while a request is evaluated and while its wakes are issued.
// Asynchronous active-low reset empties both queues and releases the lock.
// The receiver cannot stall; every result is shown for exactly one cycle.
`default_nettype none

module readers_writer_lock_controller import rwl_pkg::*; #(
  parameter int MAX_THREADS = 16,
  parameter int READER_MAX  = 255
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req_i,
  output logic      done_o,
  output res_t      res_o
);

  localparam int RC_W = $clog2(READER_MAX + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_WAKE
  } state_e;

  state_e           state_q, state_d;
  req_t             req_q, req_d;
  logic [RC_W-1:0]  rc_q, rc_d;
  logic             wh_q, wh_d;
  logic [TID_W-1:0] wt_q, wt_d;
  logic             wake_rd_q, wake_rd_d;
  logic             done_q, done_d;
  res_t             res_q, res_d;

  q_ctrl_t          rq_ctrl, wq_ctrl;
  q_stat_t          rq_stat, wq_stat;
  logic [TID_W-1:0] rq_tid, wq_tid;

  logic             tid_bad;
  status_e          st;
  logic             wake_wr;
  logic             wake_rd;
  logic             more;
  logic [TID_W-1:0] thr;

  assign tid_bad = int'(req_q.thread_id) >= MAX_THREADS;

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    rc_d      = rc_q;
    wh_d      = wh_q;
    wt_d      = wt_q;
    wake_rd_d = wake_rd_q;
    done_d    = 1'b0;
    res_d     = res_q;
    rq_ctrl   = '{push: 1'b0, pop: 1'b0, clear: 1'b0, id: req_q.thread_id};
    wq_ctrl   = '{push: 1'b0, pop: 1'b0, clear: 1'b0, id: req_q.thread_id};
    st        = ST_REFUSED;
    wake_wr   = 1'b0;
    wake_rd   = 1'b0;
    more      = 1'b0;
    thr       = wake_rd_q ? rq_tid : wq_tid;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d   = req_i;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!tid_bad) begin
          unique case (req_q.cmd)
            CMD_RD_LOCK, CMD_RD_TRY: begin
              if (!wh_q && wq_stat.empty) begin
                if (rc_q >= RC_W'(READER_MAX)) begin
                  st = ST_REFUSED;
                end else begin
                  rc_d = rc_q + RC_W'(1);
                  st   = ST_GRANTED;
                end
              end else if (req_q.cmd == CMD_RD_LOCK) begin
                rq_ctrl.push = 1'b1;
                st           = ST_BLOCKED;
              end else begin
                st = ST_REFUSED;
              end
            end
            CMD_RD_UNLOCK: begin
              if (rc_q != '0) begin
                rc_d = rc_q - RC_W'(1);
                st   = ST_RELEASED;
              end else begin
                st = ST_IGNORED;
              end
              wake_wr = (rc_q <= RC_W'(1)) && !wq_stat.empty;
            end
            CMD_WR_LOCK: begin
              if (!wh_q && rc_q == '0) begin
                wh_d = 1'b1;
                wt_d = req_q.thread_id;
                st   = ST_GRANTED;
              end else if (wh_q && wt_q == req_q.thread_id) begin
                st = ST_GRANTED;
              end else begin
                wq_ctrl.push = 1'b1;
                st           = ST_BLOCKED;
              end
            end
            CMD_WR_TRY: begin
              if (wh_q || rc_q != '0) begin
                st = ST_REFUSED;
              end else begin
                wh_d = 1'b1;
                wt_d = req_q.thread_id;
                st   = ST_GRANTED;
              end
            end
            CMD_WR_UNLOCK: begin
              if (!wh_q || wt_q != req_q.thread_id) begin
                st = ST_IGNORED;
              end else begin
                wh_d    = 1'b0;
                wt_d    = '0;
                st      = ST_RELEASED;
                wake_wr = !wq_stat.empty;
                wake_rd = wq_stat.empty && !rq_stat.empty;
              end
            end
            default: begin
              st = ST_REFUSED;
            end
          endcase
        end
        done_d = 1'b1;
        res_d  = '{kind: KIND_RESP, status: st, thread_out: req_q.thread_id,
                   last: !(wake_wr || wake_rd)};
        if (wake_wr) begin
          wq_ctrl.pop = 1'b1;
          wake_rd_d   = 1'b0;
          state_d     = S_WAKE;
        end else if (wake_rd) begin
          rq_ctrl.pop = 1'b1;
          wake_rd_d   = 1'b1;
          state_d     = S_WAKE;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_WAKE: begin
        more = wake_rd_q && !rq_stat.empty;
        if (wake_rd_q) begin
          rq_ctrl.clear = 1'b1;
          rq_ctrl.pop   = more;
        end else begin
          wq_ctrl.clear = 1'b1;
        end
        done_d = 1'b1;
        res_d  = '{kind: KIND_WAKE, status: ST_GRANTED, thread_out: thr, last: !more};
        if (!more) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      req_q     <= '0;
      rc_q      <= '0;
      wh_q      <= 1'b0;
      wt_q      <= '0;
      wake_rd_q <= 1'b0;
      done_q    <= 1'b0;
      res_q     <= '0;
    end else begin
      state_q   <= state_d;
      req_q     <= req_d;
      rc_q      <= rc_d;
      wh_q      <= wh_d;
      wt_q      <= wt_d;
      wake_rd_q <= wake_rd_d;
      done_q    <= done_d;
      res_q     <= res_d;
    end
  end

  rwl_queue #(
    .DEPTH(MAX_THREADS)
  ) u_read_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(rq_ctrl),
    .stat_o(rq_stat),
    .tid_o (rq_tid)
  );

  rwl_queue #(
    .DEPTH(MAX_THREADS)
  ) u_write_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(wq_ctrl),
    .stat_o(wq_stat),
    .tid_o (wq_tid)
  );

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire
